### design/rcps_pkg.sv
// ----------------------------------------------------------------------------
// rcps_pkg
// shared constants, operation codes and status types of the prime search
// ----------------------------------------------------------------------------
package rcps_pkg;

    localparam int VALUE_BITS_DEF = 20;
    localparam int FUNC_W         = 2;
    localparam int LIMIT_W        = 20;
    localparam int VAL_W          = 21;
    localparam int CNT_W          = 18;
    localparam int CLASS_W        = 2;
    localparam int CLASS_STRIDE   = 8;
    localparam int TWIN_GAP       = 2;

    localparam logic [FUNC_W-1:0] FUNC_NEXT_PRIME = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_NEXT_TWIN  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_COUNT_TWIN = 2'd2;

    typedef struct packed {
        logic done;
        logic rem_zero;
    } t_div_sts;

    typedef struct packed {
        logic done;
        logic prime;
    } t_prime_sts;

endpackage

### design/rcps_if.sv
// ----------------------------------------------------------------------------
// rcps_if
// request, result and configuration channels of the prime search
// ----------------------------------------------------------------------------
interface rcps_req_if
    import rcps_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [FUNC_W-1:0]  func;
    logic [LIMIT_W-1:0] limit;

    modport source (output valid, output func, output limit, input ready);
    modport sink   (input valid, input func, input limit, output ready);
endinterface

interface rcps_rsp_if
    import rcps_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] first_value;
    logic [VAL_W-1:0] second_value;
    logic [CNT_W-1:0] twin_count;
    logic             overflow;

    modport source (output valid, output first_value, output second_value,
                    output twin_count, output overflow, input ready);
    modport sink   (input valid, input first_value, input second_value,
                    input twin_count, input overflow, output ready);
endinterface

interface rcps_cfg_if
    import rcps_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [CLASS_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### design/rcps_div.sv
// ----------------------------------------------------------------------------
// rcps_div
// bit-serial restoring remainder unit, one dividend bit per cycle
// ----------------------------------------------------------------------------
module rcps_div
    import rcps_pkg::*;
#(
    parameter int W = VALUE_BITS_DEF + 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output t_div_sts     o_sts
);

    localparam int CW = $clog2(W + 1);

    logic          r_busy, n_busy;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [W-1:0]  r_shift, n_shift;
    logic [W-1:0]  r_rem, n_rem;
    logic [W-1:0]  r_dsr, n_dsr;
    t_div_sts      r_sts, n_sts;
    logic [W:0]    w_trial;

    assign w_trial = {r_rem, r_shift[W-1]};

    always_comb begin
        n_busy  = r_busy;
        n_cnt   = r_cnt;
        n_shift = r_shift;
        n_rem   = r_rem;
        n_dsr   = r_dsr;
        n_sts   = '0;
        if (r_busy) begin
            n_shift = {r_shift[W-2:0], 1'b0};
            if (w_trial >= {1'b0, r_dsr}) begin
                n_rem = W'(w_trial - {1'b0, r_dsr});
            end else begin
                n_rem = w_trial[W-1:0];
            end
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy         = 1'b0;
                n_sts.done     = 1'b1;
                n_sts.rem_zero = (n_rem == '0);
            end
        end else if (i_start) begin
            n_busy  = 1'b1;
            n_cnt   = CW'(W);
            n_shift = i_dividend;
            n_rem   = '0;
            n_dsr   = i_divisor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_sts  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
            r_sts  <= n_sts;
        end
        r_shift <= n_shift;
        r_rem   <= n_rem;
        r_dsr   <= n_dsr;
    end

    assign o_sts = r_sts;

endmodule

### design/rcps_prime.sv
// ----------------------------------------------------------------------------
// rcps_prime
// trial-division primality test over odd divisors up to the square root
// ----------------------------------------------------------------------------
module rcps_prime
    import rcps_pkg::*;
#(
    parameter int W = VALUE_BITS_DEF + 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_value,
    output t_prime_sts   o_sts
);

    typedef enum logic [3:0] {
        P_IDLE  = 4'b0001,
        P_FIRST = 4'b0010,
        P_CHECK = 4'b0100,
        P_DIV   = 4'b1000
    } t_pstate;

    t_pstate      r_state, n_state;
    logic [W-1:0] r_v, n_v;
    logic [W-1:0] r_d, n_d;
    logic [W:0]   r_sq, n_sq;
    t_prime_sts   r_sts, n_sts;
    logic         w_div_start;
    t_div_sts     w_div_sts;

    rcps_div #(.W(W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_v),
        .i_divisor  (r_d),
        .o_sts      (w_div_sts)
    );

    always_comb begin
        n_state     = r_state;
        n_v         = r_v;
        n_d         = r_d;
        n_sq        = r_sq;
        n_sts       = '0;
        w_div_start = 1'b0;
        case (r_state)
            P_IDLE: begin
                if (i_start) begin
                    n_v     = i_value;
                    n_state = P_FIRST;
                end
            end
            P_FIRST: begin
                if (r_v < W'(2)) begin
                    n_sts.done = 1'b1;
                    n_state    = P_IDLE;
                end else if (r_v < W'(4)) begin
                    n_sts.done  = 1'b1;
                    n_sts.prime = 1'b1;
                    n_state     = P_IDLE;
                end else if (!r_v[0]) begin
                    n_sts.done = 1'b1;
                    n_state    = P_IDLE;
                end else begin
                    n_d     = W'(3);
                    n_sq    = (W+1)'(9);
                    n_state = P_CHECK;
                end
            end
            P_CHECK: begin
                if (r_sq > {1'b0, r_v}) begin
                    n_sts.done  = 1'b1;
                    n_sts.prime = 1'b1;
                    n_state     = P_IDLE;
                end else begin
                    w_div_start = 1'b1;
                    n_state     = P_DIV;
                end
            end
            P_DIV: begin
                if (w_div_sts.done) begin
                    if (w_div_sts.rem_zero) begin
                        n_sts.done = 1'b1;
                        n_state    = P_IDLE;
                    end else begin
                        // (d+2)^2 = d^2 + 4d + 4
                        n_d     = r_d + W'(2);
                        n_sq    = r_sq + {r_d[W-2:0], 2'b00} + (W+1)'(4);
                        n_state = P_CHECK;
                    end
                end
            end
            default: begin
                n_state = P_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= P_IDLE;
            r_sts   <= '0;
        end else begin
            r_state <= n_state;
            r_sts   <= n_sts;
        end
        r_v  <= n_v;
        r_d  <= n_d;
        r_sq <= n_sq;
    end

    assign o_sts = r_sts;

endmodule

### design/residue_class_prime_search.sv
// ----------------------------------------------------------------------------
// residue_class_prime_search
// searches candidates q = 8m + 2c + 1 for the next prime, the next twin pair,
// or counts twin pairs below a limit, testing each candidate by trial division
//
//   port    dir  word                                             handshake
//   i_req   in   func, limit                                      valid/ready
//   o_rsp   out  first_value, second_value, twin_count, overflow  valid/ready
//   i_cfg   in   odd_class                                        valid/ready
//
// one request at a time; a request takes as long as its search runs
// each divisor is tried in the bit-serial remainder unit (W = VALUE_BITS + 2),
// and skipped candidates are stepped over without a test
// a finished word waits in the output register while the next request is taken
// reset clears control state and the residue class; i_cfg is always ready
// ----------------------------------------------------------------------------
module residue_class_prime_search
    import rcps_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    rcps_req_if.sink   i_req,
    rcps_rsp_if.source o_rsp,
    rcps_cfg_if.sink   i_cfg
);

    localparam int W  = VALUE_BITS + 2;
    localparam int LW = (VALUE_BITS < LIMIT_W) ? VALUE_BITS : LIMIT_W;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EVAL  = 5'b00010,
        S_WAIT1 = 5'b00100,
        S_WAIT2 = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    logic [CLASS_W-1:0] r_class;
    logic [FUNC_W-1:0]  r_func, n_func;
    logic [W-1:0]       r_limit, n_limit;
    logic [W-1:0]       r_q, n_q;
    logic [W-1:0]       r_first, n_first;
    logic [W-1:0]       r_second, n_second;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_ovf, n_ovf;
    logic               r_pstart, n_pstart;
    logic [W-1:0]       r_pval, n_pval;
    logic               r_o_valid, n_o_valid;
    logic [W-1:0]       r_o_first, n_o_first;
    logic [W-1:0]       r_o_second, n_o_second;
    logic [CNT_W-1:0]   r_o_cnt, n_o_cnt;
    logic               r_o_ovf, n_o_ovf;
    logic [W-1:0]       w_q2, w_qn, w_limit;
    t_prime_sts         w_psts;

    rcps_prime #(.W(W)) u_prime (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_pstart),
        .i_value (r_pval),
        .o_sts   (w_psts)
    );

    assign w_q2    = r_q + W'(TWIN_GAP);
    assign w_qn    = r_q + W'(CLASS_STRIDE);
    assign w_limit = W'(i_req.limit[LW-1:0]);

    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_state    = r_state;
        n_func     = r_func;
        n_limit    = r_limit;
        n_q        = r_q;
        n_first    = r_first;
        n_second   = r_second;
        n_cnt      = r_cnt;
        n_ovf      = r_ovf;
        n_pstart   = 1'b0;
        n_pval     = r_pval;
        n_o_valid  = r_o_valid;
        n_o_first  = r_o_first;
        n_o_second = r_o_second;
        n_o_cnt    = r_o_cnt;
        n_o_ovf    = r_o_ovf;
        if (r_o_valid && o_rsp.ready) begin
            n_o_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_func   = i_req.func;
                    n_limit  = w_limit;
                    n_q      = W'({r_class, 1'b1});
                    n_first  = '0;
                    n_second = '0;
                    n_cnt    = '0;
                    n_ovf    = 1'b0;
                    n_state  = S_EVAL;
                end
            end
            S_EVAL: begin
                case (r_func)
                    FUNC_NEXT_PRIME: begin
                        if (r_q[W-1]) begin
                            n_ovf   = 1'b1;
                            n_state = S_DONE;
                        end else if (r_q > r_limit) begin
                            n_pstart = 1'b1;
                            n_pval   = r_q;
                            n_state  = S_WAIT1;
                        end else begin
                            n_q = w_qn;
                        end
                    end
                    FUNC_NEXT_TWIN: begin
                        if (w_q2[W-1]) begin
                            n_ovf   = 1'b1;
                            n_state = S_DONE;
                        end else if (r_q > r_limit) begin
                            n_pstart = 1'b1;
                            n_pval   = r_q;
                            n_state  = S_WAIT1;
                        end else begin
                            n_q = w_qn;
                        end
                    end
                    FUNC_COUNT_TWIN: begin
                        if (r_q < r_limit) begin
                            n_pstart = 1'b1;
                            n_pval   = r_q;
                            n_state  = S_WAIT1;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_WAIT1: begin
                if (w_psts.done) begin
                    if (!w_psts.prime) begin
                        n_q     = w_qn;
                        n_state = S_EVAL;
                    end else if (r_func == FUNC_NEXT_PRIME) begin
                        n_first = r_q;
                        n_state = S_DONE;
                    end else begin
                        n_pstart = 1'b1;
                        n_pval   = w_q2;
                        n_state  = S_WAIT2;
                    end
                end
            end
            S_WAIT2: begin
                if (w_psts.done) begin
                    if (w_psts.prime && r_func == FUNC_NEXT_TWIN) begin
                        n_first  = r_q;
                        n_second = w_q2;
                        n_state  = S_DONE;
                    end else begin
                        if (w_psts.prime && r_cnt != '1) begin
                            n_cnt = r_cnt + CNT_W'(1);
                        end
                        n_q     = w_qn;
                        n_state = S_EVAL;
                    end
                end
            end
            S_DONE: begin
                if (!r_o_valid || o_rsp.ready) begin
                    n_o_valid  = 1'b1;
                    n_o_first  = r_first;
                    n_o_second = r_second;
                    n_o_cnt    = r_cnt;
                    n_o_ovf    = r_ovf;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_class   <= '0;
            r_pstart  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pstart  <= n_pstart;
            r_o_valid <= n_o_valid;
            if (i_cfg.valid) begin
                r_class <= i_cfg.data;
            end
        end
        r_func     <= n_func;
        r_limit    <= n_limit;
        r_q        <= n_q;
        r_first    <= n_first;
        r_second   <= n_second;
        r_cnt      <= n_cnt;
        r_ovf      <= n_ovf;
        r_pval     <= n_pval;
        r_o_first  <= n_o_first;
        r_o_second <= n_o_second;
        r_o_cnt    <= n_o_cnt;
        r_o_ovf    <= n_o_ovf;
    end

    generate
        if (W >= VAL_W) begin : g_out_trunc
            assign o_rsp.first_value  = r_o_first[VAL_W-1:0];
            assign o_rsp.second_value = r_o_second[VAL_W-1:0];
        end else begin : g_out_ext
            assign o_rsp.first_value  = {{(VAL_W-W){1'b0}}, r_o_first};
            assign o_rsp.second_value = {{(VAL_W-W){1'b0}}, r_o_second};
        end
    endgenerate

    assign o_rsp.valid      = r_o_valid;
    assign o_rsp.twin_count = r_o_cnt;
    assign o_rsp.overflow   = r_o_ovf;

endmodule
